// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// These are the shared forms for concurrent assertions, clocked on clk and
// disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define HID_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the first condition holds, the second must hold at the same edge.
`define HID_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/hid_pkg.sv
// ---------------------------------------------------------------------------
// hid_pkg
// Shared widths, register indexes, dimension codes and the layout decoder.
// ---------------------------------------------------------------------------
package hid_pkg;

    localparam int INDEX_BITS  = 32;
    localparam int EXTENT_BITS = 16;
    localparam int OUT_BITS    = INDEX_BITS + 1;
    localparam int LAYOUT_BITS = 4;
    localparam int CFG_ADDR_BITS = 3;
    localparam int NUM_DIMS    = 3;

    // Output item payload: three coordinates.
    localparam int OUT_DATA_BITS = NUM_DIMS * OUT_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_DATA_BITS + 7) / 8) * 8;
    localparam int IN_TDATA_BITS = ((INDEX_BITS + 7) / 8) * 8;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_BITS-1:0] REG_LAYOUT     = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LON_START  = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LON_LENGTH = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LAT_START  = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LAT_LENGTH = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LEV_START  = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] REG_LEV_LENGTH = 3'd6;

    typedef enum logic [1:0] {
        DIM_LON  = 2'd0,
        DIM_LAT  = 2'd1,
        DIM_LEV  = 2'd2,
        DIM_NONE = 2'd3
    } dim_t;

    typedef struct packed {
        logic ok;
        logic three;
        dim_t slow;
        dim_t mid;
        dim_t fast;
    } order_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] lev_coord;
        logic [OUT_BITS-1:0] lat_coord;
        logic [OUT_BITS-1:0] lon_coord;
        logic                beyond_box;
    } result_t;

    // Dimension order of each layout, slowest first. With two dimensions
    // the middle slot is unused.
    function automatic order_t decode_layout(input logic [LAYOUT_BITS-1:0] layout);
        order_t o;
        o = '{ok: 1'b1, three: 1'b0, slow: DIM_NONE, mid: DIM_NONE, fast: DIM_NONE};
        unique case (layout)
            4'd0:  begin o.slow = DIM_LON; o.fast = DIM_LAT; end
            4'd1:  begin o.slow = DIM_LAT; o.fast = DIM_LON; end
            4'd2:  begin o.slow = DIM_LAT; o.fast = DIM_LEV; end
            4'd3:  begin o.slow = DIM_LEV; o.fast = DIM_LAT; end
            4'd4:  begin o.slow = DIM_LON; o.fast = DIM_LEV; end
            4'd5:  begin o.slow = DIM_LEV; o.fast = DIM_LON; end
            4'd6:  begin o.three = 1'b1; o.slow = DIM_LON; o.mid = DIM_LAT; o.fast = DIM_LEV; end
            4'd7:  begin o.three = 1'b1; o.slow = DIM_LEV; o.mid = DIM_LON; o.fast = DIM_LAT; end
            4'd8:  begin o.three = 1'b1; o.slow = DIM_LON; o.mid = DIM_LEV; o.fast = DIM_LAT; end
            4'd9:  begin o.three = 1'b1; o.slow = DIM_LEV; o.mid = DIM_LAT; o.fast = DIM_LON; end
            4'd10: begin o.three = 1'b1; o.slow = DIM_LAT; o.mid = DIM_LEV; o.fast = DIM_LON; end
            4'd11: begin o.three = 1'b1; o.slow = DIM_LAT; o.mid = DIM_LON; o.fast = DIM_LEV; end
            default: o.ok = 1'b0;
        endcase
        return o;
    endfunction

endpackage

// File: rtl/core/hyperslab_index_delinearizer.sv
// ---------------------------------------------------------------------------
// hyperslab_index_delinearizer
// Splits a linear element index into longitude, latitude and level
// coordinates of a configured box.
// ---------------------------------------------------------------------------
// The block takes one index per cycle while the output queue has room and
// returns one result item per index, in order. On the way from acceptance to
// the offered result, two restoring dividers, one quotient bit per stage,
// split the index by the fastest and then the middle length, and one stage
// adds the starts. A two-entry output queue holds finished results, so a
// stalled consumer stops the pipeline only once both entries are full.
// Configuration is to be written only while no item is in flight; the block does not enforce it.
module hyperslab_index_delinearizer (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [hid_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
    input  logic [hid_pkg::EXTENT_BITS-1:0]        cfg_wdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // s_tdata: element_index
    input  logic [hid_pkg::IN_TDATA_BITS-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // m_tdata: lon_coord, lat_coord, lev_coord, zero pad
    output logic [hid_pkg::OUT_TDATA_BITS-1:0]     m_tdata,
    // m_tuser: beyond_box
    output logic                                   m_tuser
);

    localparam int N  = hid_pkg::INDEX_BITS;
    localparam int EB = hid_pkg::EXTENT_BITS;
    localparam int OB = hid_pkg::OUT_BITS;

    logic [hid_pkg::LAYOUT_BITS-1:0] layout_reg;
    logic [EB-1:0] start_reg  [hid_pkg::NUM_DIMS];
    logic [EB-1:0] length_reg [hid_pkg::NUM_DIMS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg <= '0;
            for (int d = 0; d < hid_pkg::NUM_DIMS; d++)
            begin
                start_reg[d]  <= '0;
                length_reg[d] <= EB'(1);
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                hid_pkg::REG_LAYOUT:     layout_reg    <= cfg_wdata[hid_pkg::LAYOUT_BITS-1:0];
                hid_pkg::REG_LON_START:  start_reg[0]  <= cfg_wdata;
                hid_pkg::REG_LON_LENGTH: length_reg[0] <= cfg_wdata;
                hid_pkg::REG_LAT_START:  start_reg[1]  <= cfg_wdata;
                hid_pkg::REG_LAT_LENGTH: length_reg[1] <= cfg_wdata;
                hid_pkg::REG_LEV_START:  start_reg[2]  <= cfg_wdata;
                hid_pkg::REG_LEV_LENGTH: length_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Static decode of the layout; the user changes it only while the block is idle (not enforced).
    hid_pkg::order_t order;
    logic [EB-1:0] len_fast, len_mid, len_slow;
    logic [EB-1:0] start_fast, start_mid, start_slow;
    logic [EB-1:0] div_fast, div_mid;
    logic          zero_used;

    assign order = hid_pkg::decode_layout(layout_reg);

    always_comb
    begin
        len_fast   = '0;
        len_mid    = EB'(1);
        len_slow   = '0;
        start_fast = '0;
        start_mid  = '0;
        start_slow = '0;
        if (order.fast != hid_pkg::DIM_NONE)
        begin
            len_fast   = length_reg[order.fast];
            start_fast = start_reg[order.fast];
        end
        if (order.mid != hid_pkg::DIM_NONE)
        begin
            len_mid   = length_reg[order.mid];
            start_mid = start_reg[order.mid];
        end
        if (order.slow != hid_pkg::DIM_NONE)
        begin
            len_slow   = length_reg[order.slow];
            start_slow = start_reg[order.slow];
        end
        // A zero length divides as one, but empties the box.
        div_fast  = (len_fast == '0) ? EB'(1) : len_fast;
        div_mid   = (len_mid == '0) ? EB'(1) : len_mid;
        zero_used = (len_fast == '0) || (len_mid == '0) || (len_slow == '0);
    end

    logic          advance;
    logic          d1_valid, d2_valid;
    logic [N-1:0]  q1, q2;
    logic [EB-1:0] r1, r2, r1_late, side_unused;

    hid_div_pipe u_div_fast (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s_tvalid && advance),
        .dividend  (s_tdata[N-1:0]),
        .divisor   (div_fast),
        .side_in   ('0),
        .out_valid (d1_valid),
        .quotient  (q1),
        .remainder (r1),
        .side_out  (side_unused)
    );

    hid_div_pipe u_div_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (d1_valid),
        .dividend  (q1),
        .divisor   (div_mid),
        .side_in   (r1 | side_unused),
        .out_valid (d2_valid),
        .quotient  (q2),
        .remainder (r2),
        .side_out  (r1_late)
    );

    // Final stage: add the starts and place each coordinate.
    logic             fin_valid_reg;
    hid_pkg::result_t fin_reg;
    hid_pkg::result_t fin_next;
    logic [OB-1:0]    c_fast, c_mid, c_slow;
    logic [OB-1:0]    coord [hid_pkg::NUM_DIMS];

    always_comb
    begin
        c_fast = OB'(start_fast) + OB'(r1_late);
        c_mid  = OB'(start_mid) + OB'(r2);
        c_slow = OB'(start_slow) + OB'(q2);
        for (int d = 0; d < hid_pkg::NUM_DIMS; d++)
        begin
            coord[d] = '0;
        end
        if (order.fast != hid_pkg::DIM_NONE)
        begin
            coord[order.fast] = c_fast;
        end
        if (order.mid != hid_pkg::DIM_NONE)
        begin
            coord[order.mid] = c_mid;
        end
        if (order.slow != hid_pkg::DIM_NONE)
        begin
            coord[order.slow] = c_slow;
        end
        fin_next.lon_coord  = coord[0];
        fin_next.lat_coord  = coord[1];
        fin_next.lev_coord  = coord[2];
        // Past the box if the slow quotient reaches its length, a length is 0 or the layout is bad.
        fin_next.beyond_box = !order.ok || zero_used || (q2 >= N'(len_slow));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            fin_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fin_reg <= fin_next;
        end
    end

    hid_pkg::result_t out_item;

    hid_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fin_valid_reg && advance),
        .push_data (fin_reg),
        .has_room  (advance),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_item)
    );

    assign s_tready = advance;
    assign m_tuser  = out_item.beyond_box;
    assign m_tdata  = hid_pkg::OUT_TDATA_BITS'({out_item.lev_coord, out_item.lat_coord,
                                                out_item.lon_coord});

endmodule

// File: rtl/core/hid_div_pipe.sv
// ---------------------------------------------------------------------------
// hid_div_pipe
// Pipelined restoring divider, one quotient bit per register stage, with a
// side payload that travels alongside the dividend.
// ---------------------------------------------------------------------------
module hid_div_pipe (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic                            in_valid,
    input  logic [hid_pkg::INDEX_BITS-1:0]  dividend,
    input  logic [hid_pkg::EXTENT_BITS-1:0] divisor,
    input  logic [hid_pkg::EXTENT_BITS-1:0] side_in,
    output logic                            out_valid,
    output logic [hid_pkg::INDEX_BITS-1:0]  quotient,
    output logic [hid_pkg::EXTENT_BITS-1:0] remainder,
    output logic [hid_pkg::EXTENT_BITS-1:0] side_out
);

    localparam int N  = hid_pkg::INDEX_BITS;
    localparam int EB = hid_pkg::EXTENT_BITS;

    logic          valid_reg [N];
    logic [EB-1:0] rem_reg   [N];
    logic [N-1:0]  q_reg     [N];
    logic [EB-1:0] side_reg  [N];

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic          prev_valid;
        logic [EB-1:0] prev_rem;
        logic [N-1:0]  prev_q;
        logic [EB-1:0] prev_side;
        logic [EB:0]   trial;
        logic [EB:0]   diff;
        logic          take;

        if (i == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev_rem   = '0;
            assign prev_q     = dividend;
            assign prev_side  = side_in;
        end else begin : g_next
            assign prev_valid = valid_reg[i-1];
            assign prev_rem   = rem_reg[i-1];
            assign prev_q     = q_reg[i-1];
            assign prev_side  = side_reg[i-1];
        end

        // Bring down the next dividend bit and try the subtraction.
        assign trial = {prev_rem, prev_q[N-1]};
        assign diff  = trial - {1'b0, divisor};
        assign take  = (trial >= {1'b0, divisor});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[i] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[i]  <= take ? diff[EB-1:0] : trial[EB-1:0];
                q_reg[i]    <= {prev_q[N-2:0], take};
                side_reg[i] <= prev_side;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign quotient  = q_reg[N-1];
    assign remainder = rem_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

// File: rtl/core/hid_out_fifo.sv
// ---------------------------------------------------------------------------
// hid_out_fifo
// Two-entry output queue that lets the pipeline keep moving while a result
// waits to be taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hid_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hid_pkg::result_t    push_data,
    output logic                has_room,
    output logic                out_valid,
    input  logic                out_ready,
    output hid_pkg::result_t    out_data
);

    hid_pkg::result_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign has_room  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `HID_ASSERT(a_count_range, count_reg != 2'd3, "output queue count out of range")
    `HID_ASSERT_IMP(a_no_overflow, push, has_room, "push into a full output queue")
    `HID_ASSERT_IMP(a_count_step, push && !pop, count_next == count_reg + 2'd1,
        "output queue count did not grow on push")

endmodule

// File: test/tb.sv
// ---------------------------------------------------------------------------
// Hyperslab index delinearizer testbench
// Streams element indexes into the block under many box layouts and checks
// every result against a local model of the mixed-radix split or a written-out value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int IB  = hid_pkg::INDEX_BITS;
    localparam int EB  = hid_pkg::EXTENT_BITS;
    localparam int OB  = hid_pkg::OUT_BITS;
    localparam int LB  = hid_pkg::LAYOUT_BITS;
    localparam int AB  = hid_pkg::CFG_ADDR_BITS;
    localparam int ITB = hid_pkg::IN_TDATA_BITS;
    localparam int OTB = hid_pkg::OUT_TDATA_BITS;

    localparam int LATENCY = 2 * IB + 1;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [OB-1:0] lon;
        logic [OB-1:0] lat;
        logic [OB-1:0] lev;
        logic          beyond;
    } coords_t;

    typedef struct {
        logic [IB-1:0] index;
        bit            typed;
        coords_t       want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [AB-1:0] cfg_addr = '0;
    logic [EB-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [ITB-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OTB-1:0] m_tdata;
    logic m_tuser;

    logic [LB-1:0] box_layout;
    logic [EB-1:0] box_start [3];
    logic [EB-1:0] box_length [3];

    coords_t expected_coords [$];
    int errors = 0;
    longint cycles = 0;
    bit calm = 1'b0;

    hyperslab_index_delinearizer i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic coords_t split_index(input logic [IB-1:0] index);
        coords_t c;
        logic [OB-1:0] pos [3];
        longint unsigned rest, product, len;
        int order [3];
        int count;
        c = '{lon: '0, lat: '0, lev: '0, beyond: 1'b1};
        if (box_layout >= 12)
            return c;
        case (box_layout)
            0: order = '{0, 1, -1};
            1: order = '{1, 0, -1};
            2: order = '{1, 2, -1};
            3: order = '{2, 1, -1};
            4: order = '{0, 2, -1};
            5: order = '{2, 0, -1};
            6: order = '{0, 1, 2};
            7: order = '{2, 0, 1};
            8: order = '{0, 2, 1};
            9: order = '{2, 1, 0};
            10: order = '{1, 2, 0};
            default: order = '{1, 0, 2};
        endcase
        count = (box_layout < 6) ? 2 : 3;
        pos = '{'0, '0, '0};
        rest = index;
        product = 1;
        for (int k = count - 1; k >= 1; k--)
        begin
            len = box_length[order[k]];
            product *= len;
            if (len == 0)
                len = 1;
            pos[order[k]] = OB'(box_start[order[k]] + (rest % len));
            rest = rest / len;
        end
        product *= box_length[order[0]];
        pos[order[0]] = OB'(box_start[order[0]] + rest);
        c.lon = pos[0];
        c.lat = pos[1];
        c.lev = pos[2];
        c.beyond = (longint'(index) >= product);
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [OB-1:0] got,
                                   input logic [OB-1:0] want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    task automatic write_reg(input logic [AB-1:0] addr,
                             input logic [EB-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        case (addr)
            hid_pkg::REG_LAYOUT: box_layout = value[LB-1:0];
            hid_pkg::REG_LON_START: box_start[0] = value;
            hid_pkg::REG_LON_LENGTH: box_length[0] = value;
            hid_pkg::REG_LAT_START: box_start[1] = value;
            hid_pkg::REG_LAT_LENGTH: box_length[1] = value;
            hid_pkg::REG_LEV_START: box_start[2] = value;
            default: box_length[2] = value;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Waits until all results are in and the pipeline has drained.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_coords.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // The item stays valid after acceptance until the next one or an idle
    // cycle replaces it.
    task automatic send_index(input logic [IB-1:0] index, input bit typed,
                              input coords_t want);
        while (!calm && $urandom_range(99) < 37)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ITB'(index);
        expected_coords.push_back(typed ? want : split_index(index));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
        m_tready <= calm || ($urandom_range(99) >= 37);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            coords_t w;
            if (expected_coords.size() == 0)
            begin
                report_mismatch("unexpected result", m_tdata[OB-1:0], '0);
            end
            else
            begin
                w = expected_coords.pop_front();
                if (m_tdata[OB-1:0] !== w.lon)
                    report_mismatch("lon_coord", m_tdata[OB-1:0], w.lon);
                if (m_tdata[2*OB-1:OB] !== w.lat)
                    report_mismatch("lat_coord", m_tdata[2*OB-1:OB], w.lat);
                if (m_tdata[3*OB-1:2*OB] !== w.lev)
                    report_mismatch("lev_coord", m_tdata[3*OB-1:2*OB], w.lev);
                if (m_tuser !== w.beyond)
                    report_mismatch("beyond_box", OB'(m_tuser), OB'(w.beyond));
            end
        end
    end

    // Random register value: extremes some of the time, small lengths mostly.
    function automatic logic [EB-1:0] pick_length();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return EB'(1);
            3: return EB'($urandom);
            default: return EB'($urandom_range(1, 40));
        endcase
    endfunction

    initial
    begin
        row_t rows [$];
        coords_t z;
        logic [IB-1:0] idx;
        longint unsigned box;
        box_layout = '0;
        box_start = '{'0, '0, '0};
        box_length = '{1, 1, 1};
        z = '{lon: '0, lat: '0, lev: '0, beyond: 1'b0};
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // After reset every length is one: only index zero lies in the box.
        rows.push_back('{index: '0, typed: 1'b1, want: z});
        rows.push_back('{index: IB'(1), typed: 1'b1,
                         want: '{lon: OB'(1), lat: '0, lev: '0, beyond: 1'b1}});
        rows.push_back('{index: '1, typed: 1'b1,
                         want: '{lon: {1'b0, {IB{1'b1}}}, lat: '0, lev: '0,
                                 beyond: 1'b1}});
        rows.push_back('{index: 32'h5555_5555, typed: 1'b0, want: z});
        rows.push_back('{index: 32'hAAAA_AAAA, typed: 1'b0, want: z});
        foreach (rows[i])
            send_index(rows[i].index, rows[i].typed, rows[i].want);
        wait_idle();

        // Every layout with extreme starts and lengths.
        for (int lay = 0; lay < 16; lay++)
        begin
            write_reg(hid_pkg::REG_LAYOUT, EB'(lay));
            write_reg(hid_pkg::REG_LON_START, '1);
            write_reg(hid_pkg::REG_LAT_START, (lay & 1) ? '1 : '0);
            write_reg(hid_pkg::REG_LEV_START, 16'h1234);
            write_reg(hid_pkg::REG_LON_LENGTH, '1);
            write_reg(hid_pkg::REG_LAT_LENGTH, (lay == 3) ? EB'(0) : EB'(3));
            write_reg(hid_pkg::REG_LEV_LENGTH, EB'(7));
            send_index('1, 1'b0, z);
            send_index('0, 1'b0, z);
            send_index(IB'(20), 1'b0, z);
            wait_idle();
        end

        for (int phase = 0; phase < 40; phase++)
        begin
            calm = (phase >= 18 && phase < 22);
            write_reg(hid_pkg::REG_LAYOUT, EB'((phase % 10 == 9) ? $urandom_range(12, 15)
                                                                 : $urandom_range(11)));
            write_reg(hid_pkg::REG_LON_START,
                      ($urandom_range(3) == 0) ? '1 : EB'($urandom));
            write_reg(hid_pkg::REG_LAT_START,
                      ($urandom_range(3) == 0) ? '0 : EB'($urandom));
            write_reg(hid_pkg::REG_LEV_START, EB'($urandom));
            write_reg(hid_pkg::REG_LON_LENGTH, pick_length());
            write_reg(hid_pkg::REG_LAT_LENGTH, pick_length());
            write_reg(hid_pkg::REG_LEV_LENGTH, pick_length());
            box = longint'(box_length[0]) * box_length[1] * box_length[2];
            repeat (24)
            begin
                case ($urandom_range(9))
                    0: idx = $urandom;
                    1: idx = '1;
                    default: idx = (box == 0) ? $urandom_range(50)
                                              : IB'($urandom % (box + 2));
                endcase
                send_index(idx, 1'b0, z);
            end
            wait_idle();
        end
        calm = 1'b0;

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
